@@ rtl/core/postfix_stack_evaluator_assert.svh @@
// assertion macros for the postfix stack evaluator
// used by modules that take this file by include, no other dependency
`ifndef POSTFIX_STACK_EVALUATOR_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_ASSERT_SVH

// checked property, disabled while reset is asserted
`define PSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked property, also active during reset
`define PSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/pse_pkg.sv @@
// shared types and constants for the postfix stack evaluator
// no dependencies
package pse_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DIV_CNT_W   = $clog2(DATA_W);

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_DIVZ  = 3'd2,
    ST_OVER  = 3'd3,
    ST_EMPTY = 3'd4
  } status_e;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/core/postfix_stack_evaluator.sv @@
// postfix evaluator: digits and whitespace stay in idle, + - * go through execute, / also
// through divide; an item flagged last then waits in finish to load the result register.
// throughput is set by the operand memory read of the lower operand and by the
// bit-serial divider; one item is in work at a time, the result register frees the input.
// reset clears stack pointer, status and control; the operand memory is not cleared.
// depends on pse_pkg, pse_div and postfix_stack_evaluator_assert.svh
`include "postfix_stack_evaluator_assert.svh"

module postfix_stack_evaluator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 char_code_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [pse_pkg::DATA_W-1:0] value_o,
  output logic [2:0]                 status_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DIV,
    S_FIN
  } state_e;

  state_e                     state_q, state_d;
  logic [pse_pkg::SP_W-1:0]   sp_q, sp_d;
  pse_pkg::status_e           err_q, err_d;
  logic [pse_pkg::DATA_W-1:0] tos_q, tos_d;
  logic [7:0]                 op_q, op_d;
  logic                       last_q, last_d;
  logic                       out_valid_q, out_valid_d;
  logic [pse_pkg::DATA_W-1:0] out_value_q, out_value_d;
  pse_pkg::status_e           out_status_q, out_status_d;

  logic [pse_pkg::DATA_W-1:0] mem [pse_pkg::STACK_DEPTH];
  logic [pse_pkg::DATA_W-1:0] rdata_q;
  logic                       mem_we, mem_re;
  logic [pse_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [pse_pkg::SP_W-1:0]   sp_m1, sp_m2;

  logic                       accept;
  logic                       is_digit, is_op;
  logic                       out_free;
  pse_pkg::div_req_t          div_req;
  pse_pkg::div_rsp_t          div_rsp;

  assign accept   = in_valid_i && in_ready_o;
  assign is_digit = (char_code_i >= pse_pkg::CH_ZERO) && (char_code_i <= pse_pkg::CH_NINE);
  assign is_op    = (char_code_i == pse_pkg::CH_PLUS) || (char_code_i == pse_pkg::CH_MINUS) ||
                    (char_code_i == pse_pkg::CH_MUL)  || (char_code_i == pse_pkg::CH_DIV);
  assign out_free = !out_valid_q || out_ready_i;
  assign sp_m1    = sp_q - pse_pkg::SP_W'(1);
  assign sp_m2    = sp_q - pse_pkg::SP_W'(2);

  // top of stack lives in tos_q, the memory holds the entries below it
  assign mem_waddr = sp_m1[pse_pkg::ADDR_W-1:0];
  assign mem_raddr = sp_m2[pse_pkg::ADDR_W-1:0];

  // next-state logic
  always_comb begin
    state_d      = state_q;
    sp_d         = sp_q;
    err_d        = err_q;
    tos_d        = tos_q;
    op_d         = op_q;
    last_d       = last_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    div_req      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = char_code_i;
          last_d = last_i;
          if (err_q == pse_pkg::ST_OK) begin
            if (is_digit) begin
              if (sp_q == pse_pkg::SP_W'(pse_pkg::STACK_DEPTH)) begin
                err_d = pse_pkg::ST_OVER;
              end else begin
                // spill the old top into the memory
                mem_we = (sp_q != '0);
                tos_d  = pse_pkg::DATA_W'(char_code_i - pse_pkg::CH_ZERO);
                sp_d   = sp_q + pse_pkg::SP_W'(1);
              end
            end else if (is_op) begin
              if (sp_q < pse_pkg::SP_W'(2)) begin
                err_d = pse_pkg::ST_UNDER;
              end else begin
                mem_re = 1'b1;
              end
            end
          end
          if (err_q == pse_pkg::ST_OK && is_op && sp_q >= pse_pkg::SP_W'(2)) begin
            state_d = S_EXEC;
          end else if (last_i) begin
            state_d = S_FIN;
          end
        end
      end
      S_READ: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        // lower operand from memory, upper operand is the top register
        state_d = last_q ? S_FIN : S_IDLE;
        sp_d    = sp_m1;
        unique case (op_q)
          pse_pkg::CH_PLUS:  tos_d = rdata_q + tos_q;
          pse_pkg::CH_MINUS: tos_d = rdata_q - tos_q;
          pse_pkg::CH_MUL:   tos_d = rdata_q * tos_q;
          default: begin
            if (tos_q == '0) begin
              err_d = pse_pkg::ST_DIVZ;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = rdata_q;
              div_req.divisor  = tos_q;
              sp_d             = sp_q;
              state_d          = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          tos_d   = div_rsp.quotient;
          sp_d    = sp_m1;
          state_d = last_q ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        // load the result once the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          if (err_q != pse_pkg::ST_OK) begin
            out_status_d = err_q;
            out_value_d  = '0;
          end else if (sp_q == '0) begin
            out_status_d = pse_pkg::ST_EMPTY;
            out_value_d  = '0;
          end else begin
            out_status_d = pse_pkg::ST_OK;
            out_value_d  = tos_q;
          end
          sp_d    = '0;
          err_d   = pse_pkg::ST_OK;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sp_q         <= '0;
      err_q        <= pse_pkg::ST_OK;
      tos_q        <= '0;
      op_q         <= '0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_status_q <= pse_pkg::ST_OK;
    end else begin
      state_q      <= state_d;
      sp_q         <= sp_d;
      err_q        <= err_d;
      tos_q        <= tos_d;
      op_q         <= op_d;
      last_q       <= last_d;
      out_valid_q  <= out_valid_d;
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
    end
  end

  // operand memory, one write and one registered read; a read never falls in the same
  // cycle as the write of the same entry
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= tos_q;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  pse_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign status_o    = out_status_q;

  // checks
  `PSE_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_q,
                     "result valid right after reset")
  `PSE_ASSERT(a_sp_bound, sp_q <= pse_pkg::SP_W'(pse_pkg::STACK_DEPTH),
              "stack pointer beyond depth")
  `PSE_ASSERT(a_div_done_state, div_rsp.done |-> state_q == S_DIV,
              "divider finished outside the divide state")
  `PSE_ASSERT(a_fin_clears, (state_q == S_FIN && out_free) |=>
              (out_valid_q && sp_q == '0 && err_q == pse_pkg::ST_OK),
              "end of expression did not load result and clear the stack")
  `PSE_ASSERT(a_err_value_zero, (out_valid_o && status_o != pse_pkg::ST_OK) |->
              value_o == '0, "error result carries a nonzero value")
  `PSE_ASSERT(a_result_from_fin, $rose(out_valid_q) |-> $past(state_q == S_FIN),
              "result appeared without an end of expression")

endmodule

@@ rtl/core/pse_div.sv @@
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// depends on pse_pkg
module pse_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pse_pkg::div_req_t req_i,
  output pse_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic                          neg_q, neg_d;
  logic [pse_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [pse_pkg::DATA_W-1:0]    rem_q, rem_d;
  logic [pse_pkg::DATA_W-1:0]    quo_q, quo_d;
  logic [pse_pkg::DATA_W-1:0]    dvs_q, dvs_d;
  logic [pse_pkg::DATA_W:0]      shifted;
  logic [pse_pkg::DATA_W:0]      diff;
  logic [pse_pkg::DATA_W-1:0]    mag_a, mag_b;

  // operand magnitudes
  assign mag_a = req_i.dividend[pse_pkg::DATA_W-1] ? (~req_i.dividend + 1'b1)
                                                   : req_i.dividend;
  assign mag_b = req_i.divisor[pse_pkg::DATA_W-1] ? (~req_i.divisor + 1'b1)
                                                  : req_i.divisor;

  // one restoring step
  assign shifted = {rem_q, quo_q[pse_pkg::DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      neg_d  = req_i.dividend[pse_pkg::DATA_W-1] ^ req_i.divisor[pse_pkg::DATA_W-1];
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = mag_a;
      dvs_d  = mag_b;
    end else if (busy_q) begin
      if (!diff[pse_pkg::DATA_W]) begin
        rem_d = diff[pse_pkg::DATA_W-1:0];
      end else begin
        rem_d = shifted[pse_pkg::DATA_W-1:0];
      end
      quo_d = {quo_q[pse_pkg::DATA_W-2:0], ~diff[pse_pkg::DATA_W]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == pse_pkg::DIV_CNT_W'(pse_pkg::DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      neg_q  <= neg_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dvs_q  <= dvs_d;
    end
  end

  // sign fix on the final quotient
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule
